@@ hw/rtl/sdtef_pkg.sv @@
// Shared types and constants of the photon detector dead-time event filter.
// No dependencies; all other files but sdtef_queue refer to this package by scope.
`default_nettype none

package sdtef_pkg;

	// Default widths of time stamps and random draws.
	localparam int TIME_BITS_DEF = 48;
	localparam int DRAW_BITS_DEF = 16;

	// Entries of the queue between classifier and result sequencer.
	localparam int QUEUE_DEPTH = 4;

	// Configuration register widths and the write channel format.
	localparam int PS_BITS       = 24;
	localparam int THR_BITS      = 17;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 24;

	// Register indexes.
	localparam logic [CFG_IDX_BITS-1:0] CFG_DEAD_TIME        = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SLOT_DURATION    = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_AFTERPULSE_DELAY = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_AFTERPULSE_THR   = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_DARK_THR         = 3'd4;

	// Register reset values.
	localparam logic [PS_BITS-1:0] SLOT_DURATION_RESET = 24'd1000;

	// Input item codes.
	localparam logic FUNC_PHOTON = 1'b0;
	localparam logic FUNC_END_OF_SLOT = 1'b1;

	// Result kinds.
	localparam logic [1:0] KIND_PHOTON     = 2'd0;
	localparam logic [1:0] KIND_AFTERPULSE = 2'd1;
	localparam logic [1:0] KIND_DARK       = 2'd2;

	typedef struct packed {
		logic [PS_BITS-1:0]  dead_ps;
		logic [PS_BITS-1:0]  window_ps;
		logic [PS_BITS-1:0]  ap_delay_ps;
		logic [THR_BITS-1:0] afterpulse_threshold;
		logic [THR_BITS-1:0] dark_threshold;
	} cfg_t;

endpackage

`default_nettype wire

@@ hw/rtl/sdtef_in_if.sv @@
// Input item channel: photon arrivals and end-of-slot markers.
// Depends on sdtef_pkg for default widths.
`default_nettype none

interface sdtef_in_if #(
	parameter int TIME_BITS = sdtef_pkg::TIME_BITS_DEF,
	parameter int DRAW_BITS = sdtef_pkg::DRAW_BITS_DEF
);
	logic                 valid;
	logic                 ready;
	logic                 func;
	logic [TIME_BITS-1:0] slot_center;
	logic [TIME_BITS-1:0] photon_time;
	logic [DRAW_BITS-1:0] draw_event;
	logic [DRAW_BITS-1:0] draw_position;

	modport source (output valid, func, slot_center, photon_time, draw_event, draw_position,
		input ready);
	modport sink (input valid, func, slot_center, photon_time, draw_event, draw_position,
		output ready);
endinterface

`default_nettype wire

@@ hw/rtl/sdtef_out_if.sv @@
// Result channel: registered detector events.
// Depends on sdtef_pkg for default widths.
`default_nettype none

interface sdtef_out_if #(
	parameter int TIME_BITS = sdtef_pkg::TIME_BITS_DEF
);
	logic                 valid;
	logic                 ready;
	logic [TIME_BITS-1:0] event_time;
	logic [1:0]           event_kind;
	logic                 last_of_run;

	modport source (output valid, event_time, event_kind, last_of_run, input ready);
	modport sink (input valid, event_time, event_kind, last_of_run, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/sdtef_cfg_if.sv @@
// Configuration write channel: register index and write data.
// Depends on sdtef_pkg for the index and data widths.
`default_nettype none

interface sdtef_cfg_if;
	logic                                 valid;
	logic                                 ready;
	logic [sdtef_pkg::CFG_IDX_BITS-1:0]   index;
	logic [sdtef_pkg::CFG_DATA_BITS-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/sdtef_front.sv @@
// Classifier: window, dead-time and random tests, detector state, dark count placement.
// Depends on sdtef_pkg and sdtef_in_if; writes one queue entry per item with results.
`default_nettype none

module sdtef_front #(
	parameter int TIME_BITS = sdtef_pkg::TIME_BITS_DEF,
	parameter int DRAW_BITS = sdtef_pkg::DRAW_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire sdtef_pkg::cfg_t   cfg,
	sdtef_in_if.sink               items,
	input  wire logic              q_full,
	output logic                   q_wr,
	output logic [TIME_BITS+1:0]   q_data
);
	localparam int DW = (DRAW_BITS > sdtef_pkg::THR_BITS) ? DRAW_BITS : sdtef_pkg::THR_BITS;
	localparam int PW = DRAW_BITS + sdtef_pkg::PS_BITS;

	logic [TIME_BITS-1:0] last_reg_q;
	logic                 any_reg_q;
	logic                 slot_reg_q;
	logic                 pend_q;
	logic [TIME_BITS-1:0] center_s1;
	logic [sdtef_pkg::PS_BITS-1:0] off_s1;

	logic                 accept;
	logic [TIME_BITS-1:0] abs_diff;
	logic                 in_win;
	logic [TIME_BITS:0]   since;
	logic                 dead_ok;
	logic                 ap_hit;
	logic                 dark_hit;
	logic                 counts;
	logic                 dark_go;
	logic [PW-1:0]        prod;
	logic [TIME_BITS:0]   dark_sum;
	logic [TIME_BITS-1:0] dark_time;
	logic                 dark_push;

	assign items.ready = !pend_q && !q_full;
	assign accept      = items.valid && items.ready;

	// Half-slot compare on the absolute distance is the exact window test.
	assign abs_diff = (items.photon_time >= items.slot_center) ?
		items.photon_time - items.slot_center : items.slot_center - items.photon_time;
	assign in_win = abs_diff <= TIME_BITS'(cfg.window_ps >> 1);

	assign since   = {1'b0, items.photon_time} - {1'b0, last_reg_q};
	assign dead_ok = !any_reg_q ||
		(!since[TIME_BITS] && since[TIME_BITS-1:0] >= TIME_BITS'(cfg.dead_ps));

	assign ap_hit   = DW'(items.draw_event) < DW'(cfg.afterpulse_threshold);
	assign dark_hit = DW'(items.draw_event) < DW'(cfg.dark_threshold);

	assign counts  = accept && (items.func == sdtef_pkg::FUNC_PHOTON) && !slot_reg_q &&
		in_win && dead_ok;
	assign dark_go = accept && (items.func == sdtef_pkg::FUNC_END_OF_SLOT) && !slot_reg_q &&
		dark_hit;

	assign prod = PW'(items.draw_position) * PW'(cfg.window_ps);

	// While a dark count is pending: place it and saturate.
	assign dark_sum  = {1'b0, center_s1} + (TIME_BITS+1)'(off_s1);
	assign dark_time = dark_sum[TIME_BITS] ? '1 : dark_sum[TIME_BITS-1:0];
	assign dark_push = pend_q && !q_full;

	assign q_wr   = counts || dark_push;
	assign q_data = pend_q ? {dark_time, 1'b1, 1'b0} : {items.photon_time, 1'b0, ap_hit};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_reg_q <= '0;
			any_reg_q  <= 1'b0;
			slot_reg_q <= 1'b0;
			pend_q     <= 1'b0;
		end else begin
			if (counts) begin
				last_reg_q <= items.photon_time;
				any_reg_q  <= 1'b1;
				slot_reg_q <= 1'b1;
			end else if (accept && (items.func == sdtef_pkg::FUNC_END_OF_SLOT)) begin
				slot_reg_q <= 1'b0;
			end
			if (dark_go) begin
				pend_q <= 1'b1;
			end else if (dark_push) begin
				pend_q     <= 1'b0;
				last_reg_q <= dark_time;
				any_reg_q  <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dark_go) begin
			center_s1 <= items.slot_center;
			off_s1    <= prod[PW-1:DRAW_BITS];
		end
	end
endmodule

`default_nettype wire

@@ hw/rtl/sdtef_queue.sv @@
// Small first-in first-out queue in flip-flops between classifier and sequencer.
// No dependencies beyond its parameters.
`default_nettype none

module sdtef_queue #(
	parameter int WIDTH = 50,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  full,
	input  wire logic             rd,
	output logic [WIDTH-1:0]      rd_data,
	output logic                  empty
);
	localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_BITS = $clog2(DEPTH + 1);

	logic [WIDTH-1:0]    mem_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;
	logic                do_wr;
	logic                do_rd;

	assign full    = count_q == CNT_BITS'(DEPTH);
	assign empty   = count_q == '0;
	assign do_wr   = wr && !full;
	assign do_rd   = rd && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_BITS'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_BITS'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CNT_BITS'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CNT_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end
endmodule

`default_nettype wire

@@ hw/rtl/sdtef_back.sv @@
// Result sequencer: turns queue entries into one or two event beats, adds afterpulse delay.
// Depends on sdtef_pkg and sdtef_out_if; holds the output register.
`default_nettype none

module sdtef_back #(
	parameter int TIME_BITS = sdtef_pkg::TIME_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire sdtef_pkg::cfg_t      cfg,
	input  wire logic                 q_empty,
	input  wire logic [TIME_BITS+1:0] q_data,
	output logic                      q_rd,
	sdtef_out_if.source               events
);
	logic                 out_valid_q;
	logic [TIME_BITS-1:0] out_time_q;
	logic [1:0]           out_kind_q;
	logic                 out_last_q;
	logic                 ap_pend_q;
	logic [TIME_BITS-1:0] ap_time_q;

	logic [TIME_BITS-1:0] head_time;
	logic                 head_dark;
	logic                 head_ap;
	logic [TIME_BITS:0]   ap_sum;
	logic                 out_free;

	assign {head_time, head_dark, head_ap} = q_data;

	assign ap_sum   = {1'b0, head_time} + (TIME_BITS+1)'(cfg.ap_delay_ps);
	assign out_free = !out_valid_q || events.ready;
	assign q_rd     = out_free && !ap_pend_q && !q_empty;

	assign events.valid       = out_valid_q;
	assign events.event_time  = out_time_q;
	assign events.event_kind  = out_kind_q;
	assign events.last_of_run = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			ap_pend_q   <= 1'b0;
		end else if (out_free) begin
			if (ap_pend_q) begin
				out_valid_q <= 1'b1;
				ap_pend_q   <= 1'b0;
			end else if (!q_empty) begin
				out_valid_q <= 1'b1;
				ap_pend_q   <= head_ap;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (ap_pend_q) begin
				out_time_q <= ap_time_q;
				out_kind_q <= sdtef_pkg::KIND_AFTERPULSE;
				out_last_q <= 1'b1;
			end else if (!q_empty) begin
				out_time_q <= head_time;
				out_kind_q <= head_dark ? sdtef_pkg::KIND_DARK : sdtef_pkg::KIND_PHOTON;
				out_last_q <= !head_ap;
				ap_time_q  <= ap_sum[TIME_BITS] ? '1 : ap_sum[TIME_BITS-1:0];
			end
		end
	end
endmodule

`default_nettype wire

@@ hw/rtl/spad_dead_time_event_filter.sv @@
// A photon registration goes through the queue, then the output register; a dark count
// is first placed in a pending stage, then goes the same way; an afterpulse follows its
// registration in the next beat. Throughput: one item per cycle while the queue is not
// full; an item that yields a dark count holds input ready low while the dark time is
// placed, and an afterpulse item takes two output beats. Reset: registers return to
// their reset values, detector state and queue clear at once; there is no clearing pass.
`default_nettype none

module spad_dead_time_event_filter #(
	parameter int TIME_BITS = sdtef_pkg::TIME_BITS_DEF,
	parameter int DRAW_BITS = sdtef_pkg::DRAW_BITS_DEF
) (
	input wire logic     clk,
	input wire logic     arst_n,
	sdtef_in_if.sink     items,
	sdtef_out_if.source  events,
	sdtef_cfg_if.sink    cfg
);
	sdtef_pkg::cfg_t cfg_q;

	logic                 q_wr;
	logic [TIME_BITS+1:0] q_wr_data;
	logic                 q_full;
	logic                 q_rd;
	logic [TIME_BITS+1:0] q_rd_data;
	logic                 q_empty;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dead_ps              <= '0;
			cfg_q.window_ps            <= sdtef_pkg::SLOT_DURATION_RESET;
			cfg_q.ap_delay_ps          <= '0;
			cfg_q.afterpulse_threshold <= '0;
			cfg_q.dark_threshold       <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				sdtef_pkg::CFG_DEAD_TIME: begin
					cfg_q.dead_ps <= cfg.data;
				end
				sdtef_pkg::CFG_SLOT_DURATION: begin
					cfg_q.window_ps <= cfg.data;
				end
				sdtef_pkg::CFG_AFTERPULSE_DELAY: begin
					cfg_q.ap_delay_ps <= cfg.data;
				end
				sdtef_pkg::CFG_AFTERPULSE_THR: begin
					cfg_q.afterpulse_threshold <= cfg.data[sdtef_pkg::THR_BITS-1:0];
				end
				sdtef_pkg::CFG_DARK_THR: begin
					cfg_q.dark_threshold <= cfg.data[sdtef_pkg::THR_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	sdtef_front #(
		.TIME_BITS (TIME_BITS),
		.DRAW_BITS (DRAW_BITS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.items  (items),
		.q_full (q_full),
		.q_wr   (q_wr),
		.q_data (q_wr_data)
	);

	sdtef_queue #(
		.WIDTH (TIME_BITS + 2),
		.DEPTH (sdtef_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_wr),
		.wr_data (q_wr_data),
		.full    (q_full),
		.rd      (q_rd),
		.rd_data (q_rd_data),
		.empty   (q_empty)
	);

	sdtef_back #(
		.TIME_BITS (TIME_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_empty (q_empty),
		.q_data  (q_rd_data),
		.q_rd    (q_rd),
		.events  (events)
	);
endmodule

`default_nettype wire
